// ===== sv/mie_pkg.sv =====
// Shared types and constants for the integer execute unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package mie_pkg;

   typedef logic [5:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type K_ADD    = 6'd0;
   localparam kind_type K_ADDI   = 6'd1;
   localparam kind_type K_ADDIU  = 6'd2;
   localparam kind_type K_ADDU   = 6'd3;
   localparam kind_type K_AND    = 6'd4;
   localparam kind_type K_ANDI   = 6'd5;
   localparam kind_type K_BEQ    = 6'd6;
   localparam kind_type K_BGEZ   = 6'd7;
   localparam kind_type K_BGEZAL = 6'd8;
   localparam kind_type K_BGTZ   = 6'd9;
   localparam kind_type K_BLEZ   = 6'd10;
   localparam kind_type K_BLTZ   = 6'd11;
   localparam kind_type K_BLTZAL = 6'd12;
   localparam kind_type K_BNE    = 6'd13;
   localparam kind_type K_DIV    = 6'd14;
   localparam kind_type K_DIVU   = 6'd15;
   localparam kind_type K_J      = 6'd16;
   localparam kind_type K_JALR   = 6'd17;
   localparam kind_type K_JAL    = 6'd18;
   localparam kind_type K_JR     = 6'd19;
   localparam kind_type K_LUI    = 6'd24;
   localparam kind_type K_MFHI   = 6'd28;
   localparam kind_type K_MFLO   = 6'd29;
   localparam kind_type K_MTHI   = 6'd30;
   localparam kind_type K_MTLO   = 6'd31;
   localparam kind_type K_MULT   = 6'd32;
   localparam kind_type K_MULTU  = 6'd33;
   localparam kind_type K_OR     = 6'd34;
   localparam kind_type K_ORI    = 6'd35;
   localparam kind_type K_SLL    = 6'd38;
   localparam kind_type K_SLLV   = 6'd39;
   localparam kind_type K_SLT    = 6'd40;
   localparam kind_type K_SLTI   = 6'd41;
   localparam kind_type K_SLTIU  = 6'd42;
   localparam kind_type K_SLTU   = 6'd43;
   localparam kind_type K_SRA    = 6'd44;
   localparam kind_type K_SRAV   = 6'd45;
   localparam kind_type K_SRL    = 6'd46;
   localparam kind_type K_SRLV   = 6'd47;
   localparam kind_type K_SUB    = 6'd48;
   localparam kind_type K_SUBU   = 6'd49;
   localparam kind_type K_XOR    = 6'd51;
   localparam kind_type K_XORI   = 6'd52;

   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_OVERFLOW    = 2'd1;
   localparam status_type ST_UNSUPPORTED = 2'd2;

   localparam logic [4:0]  RA_INDEX     = 5'd31;
   localparam logic [4:0]  DIV_LAST     = 5'd31;
   localparam logic [31:0] PC_STEP      = 32'd4;
   localparam logic [31:0] PC_SEG_MASK  = 32'hF000_0000;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_D,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_DIV_FIN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic read_d;
      logic exec;
      logic mul_wr;
      logic div_step;
      logic div_fin;
   } cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } dp_status_type;

endpackage

// ===== sv/mie_ctrl.sv =====
// Controller state machine for the integer execute unit.
// Depends on mie_pkg; drives the datapath through a command struct.
module mie_ctrl import mie_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type dp_stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_READ_D;
         end
         S_READ_D: state_in = S_EXEC;
         S_EXEC: begin
            if (dp_stat.is_mul) state_in = S_MUL;
            else if (dp_stat.is_div) state_in = S_DIV;
            else state_in = S_RESP;
         end
         S_MUL: state_in = S_RESP;
         S_DIV: begin
            if (dp_stat.div_last) state_in = S_DIV_FIN;
         end
         S_DIV_FIN: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_READ_D:  cmd.read_d   = 1'b1;
         S_EXEC:    cmd.exec     = 1'b1;
         S_MUL:     cmd.mul_wr   = 1'b1;
         S_DIV:     cmd.div_step = 1'b1;
         S_DIV_FIN: cmd.div_fin  = 1'b1;
         S_RESP:    rsp_tvalid   = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/mie_dp.sv =====
// Datapath of the integer execute unit: register file, HI/LO, PC, ALU,
// multiplier and radix-2 divider. Depends on mie_pkg; steered by mie_ctrl.
module mie_dp import mie_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output dp_status_type dp_stat,
   input  logic          csr_write,
   input  logic [31:0]   csr_data,
   input  kind_type      in_kind,
   input  logic [4:0]    in_dest,
   input  logic [4:0]    in_src1,
   input  logic [4:0]    in_src2,
   input  logic [15:0]   in_imm,
   input  logic [4:0]    in_shift,
   input  logic [25:0]   in_target,
   output logic          out_we,
   output logic [4:0]    out_widx,
   output logic [31:0]   out_wval,
   output logic [31:0]   out_next_pc,
   output logic          out_taken,
   output status_type    out_status
);

   // Item fields held for the whole transaction.
   kind_type    kind_ff;
   logic [4:0]  dest_ff;
   logic [15:0] imm_ff;
   logic [4:0]  shift_ff;
   logic [25:0] target_ff;

   // Register file memory, valid bits give the all-zero reset.
   logic [31:0] gpr_mem [32];
   logic [31:0] gpr_vld_ff;
   logic [31:0] rdata_a_ff, rdata_b_ff;
   logic        rvld_a_ff, rvld_b_ff;
   logic [4:0]  addr_a;

   logic [31:0] a_ff, b_ff, d;
   logic [31:0] pc_ff, hi_ff, lo_ff;

   logic [63:0] prod_ff;
   logic        mul_signed_ff;

   logic [31:0] quo_ff, rem_ff, den_ff;
   logic [4:0]  cnt_ff;
   logic        neg_q_ff, neg_r_ff;
   logic [32:0] div_shift;
   logic        div_ge;

   logic [31:0] simm, zimm, pc4, link, btarget, jtarget, sum, r_add, r_sub;
   logic        we, taken, cond;
   logic [4:0]  widx;
   logic [31:0] wval, next_pc;
   status_type  status;
   logic        na, nb;

   assign addr_a = cmd.load ? in_src1 : dest_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= in_kind;
         dest_ff   <= in_dest;
         imm_ff    <= in_imm;
         shift_ff  <= in_shift;
         target_ff <= in_target;
         rdata_b_ff <= gpr_mem[in_src2];
      end
      if (cmd.load || cmd.read_d) begin
         rdata_a_ff <= gpr_mem[addr_a];
      end
      if (cmd.exec && we) begin
         gpr_mem[widx] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_vld_ff <= '0;
         rvld_a_ff  <= 1'b0;
         rvld_b_ff  <= 1'b0;
      end else begin
         if (cmd.load) rvld_b_ff <= gpr_vld_ff[in_src2];
         if (cmd.load || cmd.read_d) rvld_a_ff <= gpr_vld_ff[addr_a];
         if (cmd.exec && we) gpr_vld_ff[widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_d) begin
         a_ff <= rvld_a_ff ? rdata_a_ff : '0;
         b_ff <= rvld_b_ff ? rdata_b_ff : '0;
      end
   end

   assign d = rvld_a_ff ? rdata_a_ff : '0;

   // Execute logic, evaluated in the execute cycle.
   assign simm    = {{16{imm_ff[15]}}, imm_ff};
   assign zimm    = {16'd0, imm_ff};
   assign pc4     = pc_ff + PC_STEP;
   assign link    = pc4 + PC_STEP;
   assign btarget = pc4 + {simm[29:0], 2'b00};
   assign jtarget = (pc4 & PC_SEG_MASK) + {4'd0, target_ff, 2'b00};
   assign sum     = a_ff + ((kind_ff == K_ADDI) ? simm : b_ff);
   assign r_add   = sum;
   assign r_sub   = a_ff - b_ff;

   always_comb begin
      we      = 1'b0;
      widx    = dest_ff;
      wval    = '0;
      next_pc = pc4;
      taken   = 1'b0;
      status  = ST_OK;
      cond    = 1'b0;
      case (kind_ff)
         K_ADD, K_ADDI: begin
            if (kind_ff == K_ADD) cond = ((a_ff ^ r_add) & (b_ff ^ r_add)) >> 31 != 0;
            else cond = ((a_ff ^ r_add) & (simm ^ r_add)) >> 31 != 0;
            if (cond) status = ST_OVERFLOW;
            else begin
               we   = 1'b1;
               wval = r_add;
            end
         end
         K_SUB: begin
            cond = ((a_ff ^ b_ff) & (a_ff ^ r_sub)) >> 31 != 0;
            if (cond) status = ST_OVERFLOW;
            else begin
               we   = 1'b1;
               wval = r_sub;
            end
         end
         K_ADDIU: begin we = 1'b1; wval = a_ff + simm; end
         K_ADDU:  begin we = 1'b1; wval = a_ff + b_ff; end
         K_AND:   begin we = 1'b1; wval = a_ff & b_ff; end
         K_ANDI:  begin we = 1'b1; wval = a_ff & zimm; end
         K_OR:    begin we = 1'b1; wval = a_ff | b_ff; end
         K_ORI:   begin we = 1'b1; wval = a_ff | zimm; end
         K_XOR:   begin we = 1'b1; wval = a_ff ^ b_ff; end
         K_XORI:  begin we = 1'b1; wval = a_ff ^ zimm; end
         K_SUBU:  begin we = 1'b1; wval = r_sub; end
         K_LUI:   begin we = 1'b1; wval = {imm_ff, 16'd0}; end
         K_SLT:   begin we = 1'b1; wval = {31'd0, $signed(a_ff) < $signed(b_ff)}; end
         K_SLTI:  begin we = 1'b1; wval = {31'd0, $signed(a_ff) < $signed(simm)}; end
         K_SLTIU: begin we = 1'b1; wval = {31'd0, a_ff < simm}; end
         K_SLTU:  begin we = 1'b1; wval = {31'd0, a_ff < b_ff}; end
         K_SLL:   begin we = 1'b1; wval = b_ff << shift_ff; end
         K_SLLV:  begin we = 1'b1; wval = b_ff << a_ff[4:0]; end
         K_SRA:   begin we = 1'b1; wval = $unsigned($signed(b_ff) >>> shift_ff); end
         K_SRAV:  begin we = 1'b1; wval = $unsigned($signed(b_ff) >>> a_ff[4:0]); end
         K_SRL:   begin we = 1'b1; wval = b_ff >> shift_ff; end
         K_SRLV:  begin we = 1'b1; wval = b_ff >> a_ff[4:0]; end
         K_BEQ, K_BNE, K_BGEZ, K_BGEZAL, K_BGTZ, K_BLEZ, K_BLTZ, K_BLTZAL: begin
            if (kind_ff == K_BEQ) cond = (a_ff == d);
            else if (kind_ff == K_BNE) cond = (a_ff != d);
            else if (kind_ff == K_BGEZ || kind_ff == K_BGEZAL) cond = !a_ff[31];
            else if (kind_ff == K_BGTZ) cond = !a_ff[31] && (a_ff != '0);
            else if (kind_ff == K_BLEZ) cond = a_ff[31] || (a_ff == '0);
            else cond = a_ff[31];
            if (kind_ff == K_BGEZAL || kind_ff == K_BLTZAL) begin
               we   = 1'b1;
               widx = RA_INDEX;
               wval = link;
            end
            if (cond) begin
               taken   = 1'b1;
               next_pc = btarget;
            end
         end
         K_J:   begin taken = 1'b1; next_pc = jtarget; end
         K_JAL: begin
            we = 1'b1; widx = RA_INDEX; wval = link; taken = 1'b1; next_pc = jtarget;
         end
         K_JALR: begin we = 1'b1; wval = link; taken = 1'b1; next_pc = a_ff; end
         K_JR:   begin taken = 1'b1; next_pc = a_ff; end
         K_MFHI: begin we = 1'b1; wval = hi_ff; end
         K_MFLO: begin we = 1'b1; wval = lo_ff; end
         K_DIV, K_DIVU, K_MTHI, K_MTLO, K_MULT, K_MULTU: begin
            status = ST_OK;
         end
         default: status = ST_UNSUPPORTED;
      endcase
      // Register zero is never written.
      if (widx == '0) we = 1'b0;
      if (!we) begin
         widx = '0;
         wval = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         out_we      <= we;
         out_widx    <= widx;
         out_wval    <= wval;
         out_next_pc <= next_pc;
         out_taken   <= taken;
         out_status  <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (csr_write) begin
         pc_ff <= csr_data;
      end else if (cmd.exec) begin
         pc_ff <= next_pc;
      end
   end

   // Multiply: unsigned product first, signed correction of HI after it.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         prod_ff       <= a_ff * b_ff;
         mul_signed_ff <= (kind_ff == K_MULT);
      end
   end

   // Divide: magnitudes go through a restoring divider, one bit a cycle.
   assign na        = (kind_ff == K_DIV) && a_ff[31];
   assign nb        = (kind_ff == K_DIV) && b_ff[31];
   assign div_shift = {rem_ff, quo_ff[31]};
   assign div_ge    = div_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         quo_ff   <= na ? (32'd0 - a_ff) : a_ff;
         den_ff   <= nb ? (32'd0 - b_ff) : b_ff;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         neg_q_ff <= na ^ nb;
         neg_r_ff <= na;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? 32'(div_shift - {1'b0, den_ff}) : div_shift[31:0];
         quo_ff <= {quo_ff[30:0], div_ge};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (cmd.exec && kind_ff == K_MTHI) begin
         hi_ff <= a_ff;
      end else if (cmd.exec && kind_ff == K_MTLO) begin
         lo_ff <= a_ff;
      end else if (cmd.mul_wr) begin
         hi_ff <= prod_ff[63:32]
                  - ((mul_signed_ff && a_ff[31]) ? b_ff : 32'd0)
                  - ((mul_signed_ff && b_ff[31]) ? a_ff : 32'd0);
         lo_ff <= prod_ff[31:0];
      end else if (cmd.div_fin) begin
         lo_ff <= neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
         hi_ff <= neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
      end
   end

   assign dp_stat.is_mul   = (kind_ff == K_MULT) || (kind_ff == K_MULTU);
   assign dp_stat.is_div   = ((kind_ff == K_DIV) || (kind_ff == K_DIVU)) && (b_ff != '0);
   assign dp_stat.div_last = (cnt_ff == DIV_LAST);

endmodule

// ===== sv/mips_integer_execute_unit.sv =====
// Top level of the integer execute unit: joins controller and datapath.
// Depends on mie_pkg, mie_ctrl and mie_dp.
//
// Usage: one pre-decoded instruction enters on the req_ stream channel and
// exactly one result leaves on the rsp_ channel. The unit handles one
// instruction at a time: req_tready is high only while no instruction is in
// work. An ordinary instruction raises rsp_tvalid after a second register
// file read and then the execute cycle; with a ready sink the result
// transaction completes in S_RESP and the unit is ready again the cycle
// after, so a new instruction is taken only once the last one is delivered.
// mult and multu add the HI correction step after the multiplier;
// div and divu with a nonzero divisor add the steps of the radix-2
// divider, which retires one quotient bit per cycle, and a final sign step.
// The csr_ channel loads start_pc into the program counter; it is always
// ready and is meant to be written only while the unit is idle.
// Reset clears all general registers, HI and LO and sets the PC to zero.
// When the sink holds rsp_tready low the result stays registered and
// stable, and no new instruction is taken until it is delivered.
module mips_integer_execute_unit import mie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[5:0], dest_index[10:6], src1_index[15:11], src2_index[20:16],
   // imm_value[36:21], shift_count[41:37], jump_target[67:42], zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_enable[0], write_index[5:1], write_value[37:6], next_pc[69:38],
   // branch_taken[70], status[72:71], zero fill
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   cmd_type       cmd;
   dp_status_type dp_stat;
   logic          o_we, o_taken;
   logic [4:0]    o_widx;
   logic [31:0]   o_wval, o_next;
   status_type    o_status;

   assign csr_ready = 1'b1;

   mie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   mie_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_stat     (dp_stat),
      .csr_write   (csr_valid & csr_ready),
      .csr_data    (csr_data),
      .in_kind     (req_tdata[5:0]),
      .in_dest     (req_tdata[10:6]),
      .in_src1     (req_tdata[15:11]),
      .in_src2     (req_tdata[20:16]),
      .in_imm      (req_tdata[36:21]),
      .in_shift    (req_tdata[41:37]),
      .in_target   (req_tdata[67:42]),
      .out_we      (o_we),
      .out_widx    (o_widx),
      .out_wval    (o_wval),
      .out_next_pc (o_next),
      .out_taken   (o_taken),
      .out_status  (o_status)
   );

   assign rsp_tdata = {7'd0, o_status, o_taken, o_next, o_wval, o_widx, o_we};

endmodule

// ===== sv/mie_checker.sv =====
// Port-level checks for the integer execute unit, bound to the top level.
// Depends only on the top level's ports.
module mie_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // A pending result stays offered until the sink takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before transaction");

   // Only one instruction is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second instruction accepted while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result is pending");

   // Register zero is never reported as written, and a trap writes nothing.
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[5:1] != 5'd0 && rsp_tdata[72:71] == 2'd0)
      else $error("bad register write report");

endmodule

bind mips_integer_execute_unit mie_checker u_mie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
